// File: rtl/core/lkmlc_pkg.sv
// Shared constants and widths for the ladder keypad mode and level controller.
package lkmlc_pkg;

    // Defaults for the top-level parameters
    localparam int ADJUST_GAP_MS_DEF = 36;
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int STAMP_BITS_DEF    = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY1_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_MS = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS   = 3'd7;

    // Reset values of the registers
    localparam int KEY1_LOW_RST  = 820;
    localparam int KEY1_HIGH_RST = 900;
    localparam int KEY2_LOW_RST  = 400;
    localparam int KEY2_HIGH_RST = 500;
    localparam int KEY3_LOW_RST  = 600;
    localparam int KEY3_HIGH_RST = 800;
    localparam logic [MS_W-1:0] SETTLE_MS_RST = 16'd50;
    localparam logic [MS_W-1:0] HOLD_MS_RST   = 16'd1000;

    // Result fields
    localparam int MODE_W  = 2;
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_RST = 8'd100;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_X    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_R    = 2'd2;

    localparam int OUT_BITS = MODE_W + 2 * LEVEL_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// File: rtl/core/ladder_keypad_mode_level_control_unit.sv
// Ladder keypad decode, mode button debounce with long press, and rate-limited level control.
// A sample transaction passes through the input register, then the result register;
//   the state update is one pass of short logic.
// Throughput: one transaction per cycle; stalls on m_tready back up through both registers.
// Reset (aresetn, synchronous, active low): registers at their defaults, mode idle,
//   both levels at 100, all timestamps zero, both pipeline registers empty.
module ladder_keypad_mode_level_control_unit
    import lkmlc_pkg::*;
#(
    parameter int ADJUST_GAP_MS = ADJUST_GAP_MS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int STAMP_BITS    = STAMP_BITS_DEF,
    localparam int IN_BITS      = SAMPLE_BITS + STAMP_BITS,
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // Sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,   // sample, now_ms, zero pad

    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata    // mode, level_x, level_r, persist, zero pad
);

    localparam logic [STAMP_BITS-1:0] GAP = STAMP_BITS'(ADJUST_GAP_MS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] key1_low_reg, key1_high_reg;
    logic [SAMPLE_BITS-1:0] key2_low_reg, key2_high_reg;
    logic [SAMPLE_BITS-1:0] key3_low_reg, key3_high_reg;
    logic [MS_W-1:0]        settle_ms_reg, hold_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key1_low_reg  <= SAMPLE_BITS'(KEY1_LOW_RST);
            key1_high_reg <= SAMPLE_BITS'(KEY1_HIGH_RST);
            key2_low_reg  <= SAMPLE_BITS'(KEY2_LOW_RST);
            key2_high_reg <= SAMPLE_BITS'(KEY2_HIGH_RST);
            key3_low_reg  <= SAMPLE_BITS'(KEY3_LOW_RST);
            key3_high_reg <= SAMPLE_BITS'(KEY3_HIGH_RST);
            settle_ms_reg <= SETTLE_MS_RST;
            hold_ms_reg   <= HOLD_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY1_LOW:  key1_low_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_KEY1_HIGH: key1_high_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_KEY2_LOW:  key2_low_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_KEY2_HIGH: key2_high_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_KEY3_LOW:  key3_low_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_KEY3_HIGH: key3_high_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_SETTLE_MS: settle_ms_reg <= cfg_wdata[MS_W-1:0];
                REG_HOLD_MS:   hold_ms_reg   <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [STAMP_BITS-1:0]  in_now_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_open;   // result register can take a value this cycle
    logic                   step;       // the registered sample is processed this cycle

    assign out_open = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_open;
    assign s_tready = !in_valid_reg || out_open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_now_reg    <= s_tdata[IN_BITS-1:SAMPLE_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic                  raw_prev_reg, held_reg, long_fired_reg;
    logic [STAMP_BITS-1:0] change_stamp_reg, press_stamp_reg, adjust_stamp_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [LEVEL_W-1:0]    x_level_reg, r_level_reg;

    logic                  held_next, long_fired_next;
    logic [STAMP_BITS-1:0] change_stamp_next, press_stamp_next, adjust_stamp_next;
    logic [MODE_W-1:0]     mode_next;
    logic [LEVEL_W-1:0]    x_level_next, r_level_next;

    logic                  raw, up, down, settled, adjust_ok;
    logic [STAMP_BITS-1:0] settle_ext, hold_ext;

    assign raw  = (in_sample_reg >= key1_low_reg) && (in_sample_reg <= key1_high_reg);
    assign up   = (in_sample_reg >= key2_low_reg) && (in_sample_reg <= key2_high_reg);
    // increase wins where both windows cover the sample
    assign down = !up && (in_sample_reg >= key3_low_reg) && (in_sample_reg <= key3_high_reg);

    assign settle_ext = STAMP_BITS'(settle_ms_reg);
    assign hold_ext   = STAMP_BITS'(hold_ms_reg);

    // Elapsed times are plain modular differences at STAMP_BITS
    assign change_stamp_next = (raw != raw_prev_reg) ? in_now_reg : change_stamp_reg;
    assign settled           = (in_now_reg - change_stamp_next) > settle_ext;
    assign adjust_ok         = (up || down) && ((in_now_reg - adjust_stamp_reg) >= GAP);
    assign adjust_stamp_next = adjust_ok ? in_now_reg : adjust_stamp_reg;

    always_comb begin
        held_next        = held_reg;
        long_fired_next  = long_fired_reg;
        press_stamp_next = press_stamp_reg;
        mode_next        = mode_reg;

        if (settled) begin
            if (raw && !held_reg) begin
                press_stamp_next = in_now_reg;
                held_next        = 1'b1;
                long_fired_next  = 1'b0;
            end else if (!raw && held_reg) begin
                held_next = 1'b0;
                // short release toggles; a late release without long press does nothing
                if (!long_fired_reg && ((in_now_reg - press_stamp_reg) < hold_ext)) begin
                    mode_next = (mode_reg == MODE_IDLE) ? MODE_X : MODE_IDLE;
                end
            end
        end

        // long press fires once per hold, possibly in the same pass as the press
        if (held_next && !long_fired_next && ((in_now_reg - press_stamp_next) >= hold_ext)) begin
            mode_next       = MODE_R;
            long_fired_next = 1'b1;
        end
    end

    // Level adjust uses the mode after this pass's button handling
    always_comb begin
        x_level_next = x_level_reg;
        r_level_next = r_level_reg;
        if (adjust_ok) begin
            case (mode_next)
                MODE_X: begin
                    if (up && x_level_reg != LEVEL_MAX) begin
                        x_level_next = x_level_reg + LEVEL_W'(1);
                    end else if (down && x_level_reg != LEVEL_MIN) begin
                        x_level_next = x_level_reg - LEVEL_W'(1);
                    end
                end
                MODE_R: begin
                    if (up && r_level_reg != LEVEL_MAX) begin
                        r_level_next = r_level_reg + LEVEL_W'(1);
                    end else if (down && r_level_reg != LEVEL_MIN) begin
                        r_level_next = r_level_reg - LEVEL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_prev_reg     <= 1'b0;
            held_reg         <= 1'b0;
            long_fired_reg   <= 1'b0;
            change_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            adjust_stamp_reg <= '0;
            mode_reg         <= MODE_IDLE;
            x_level_reg      <= LEVEL_RST;
            r_level_reg      <= LEVEL_RST;
        end else if (step) begin
            raw_prev_reg     <= raw;
            held_reg         <= held_next;
            long_fired_reg   <= long_fired_next;
            change_stamp_reg <= change_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            adjust_stamp_reg <= adjust_stamp_next;
            mode_reg         <= mode_next;
            x_level_reg      <= x_level_next;
            r_level_reg      <= r_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_open) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {{(OUT_W - OUT_BITS){1'b0}}, adjust_ok,
                             r_level_next, x_level_next, mode_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != 2'd3)
        else $error("mode register holds an unused code");

    a_held_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_now_reg)
                                  && $stable(in_sample_reg))
        else $error("stalled sample lost from input register");

    a_no_persist_no_level: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !adjust_ok |=> $stable(x_level_reg) && $stable(r_level_reg))
        else $error("level changed without an allowed adjust");

    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(held_reg) && $stable(adjust_stamp_reg))
        else $error("controller state moved without a sample");

    a_long_fire_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        step && long_fired_next && !long_fired_reg |=> mode_reg == MODE_R)
        else $error("long press did not force R mode");

endmodule
